// ----- hw/rtl/hrlp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_pkg
// shared types, codes and helpers for the http request line parser
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int LINE_MAX  = 4096;
    localparam int OFF_W     = $clog2(LINE_MAX) + 1;   // holds LINE_MAX itself
    localparam int OUT_OFF_W = 12;
    localparam int VER_W     = 10;
    localparam int ACC10_W   = VER_W + 4;

    localparam logic [VER_W-1:0] VER_SAT = VER_W'(999);

    typedef enum logic [1:0] {
        ST_MORE       = 2'd0,
        ST_DONE       = 2'd1,
        ST_BAD_METHOD = 2'd2,
        ST_BAD_REQ    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MK_UNKNOWN = 2'd0,
        MK_GET     = 2'd1,
        MK_HEAD    = 2'd2,
        MK_POST    = 2'd3
    } method_kind_t;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [23:0] WORD_GET  = "GET";
    localparam logic [31:0] WORD_HEAD = "HEAD";
    localparam logic [31:0] WORD_POST = "POST";

    // acc * 10 + digit, saturating at VER_SAT
    function automatic logic [VER_W-1:0] add_digit(input logic [VER_W-1:0] acc,
                                                   input logic [3:0] digit);
        logic [ACC10_W-1:0] sum;
        sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + ACC10_W'(digit);
        if (sum > ACC10_W'(VER_SAT)) begin
            return VER_SAT;
        end
        return sum[VER_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/http_request_line_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_parser
// byte-wide request line checker: method, uri bounds, version, line end
// ----------------------------------------------------------------------------
// the result word of an accepted byte is registered in the output register
// throughput: one byte per cycle while s_ready is high; the parse state is updated in the same cycle
//   a byte is taken, so the next byte may follow right behind it
// s_ready is high whenever the output register is empty or being drained
// reset (aresetn low, synchronous) clears the parse state to the start phase
//   and empties the output register
module http_request_line_parser
    import hrlp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // byte stream in
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    // one result word per byte
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [1:0]           m_method_kind,
    output logic [OUT_OFF_W-1:0] m_uri_begin,
    output logic [OUT_OFF_W-1:0] m_uri_finish,
    output logic [OUT_OFF_W-1:0] m_line_finish,
    output logic [VER_W-1:0]     m_version_major,
    output logic [VER_W-1:0]     m_version_minor
);

    typedef enum logic [3:0] {
        PH_START, PH_METHOD, PH_SP_URI, PH_URI, PH_SP_HTTP, PH_H, PH_HT, PH_HTT,
        PH_HTTP, PH_MAJ_FIRST, PH_MAJ, PH_MIN_FIRST, PH_MIN, PH_SP_END, PH_CR
    } phase_t;

    // parse state
    phase_t             phase_reg, phase_next;
    logic [OFF_W-1:0]   offset_reg, offset_next;
    logic [31:0]        mchars_reg, mchars_next;
    logic [2:0]         mlen_reg, mlen_next;
    method_kind_t       mcode_reg, mcode_next;
    logic [OFF_W-1:0]   uri_start_reg, uri_start_next;
    logic [OFF_W-1:0]   uri_end_reg, uri_end_next;
    logic [VER_W-1:0]   major_reg, major_next;
    logic [VER_W-1:0]   minor_reg, minor_next;

    // output register
    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [1:0]           out_kind_reg;
    logic [OUT_OFF_W-1:0] out_ubeg_reg, out_uend_reg, out_lend_reg;
    logic [VER_W-1:0]     out_maj_reg, out_min_reg;

    // per-byte decode
    logic [7:0]       c;
    logic [OFF_W-1:0] cur;
    logic [OFF_W-1:0] line_end;
    status_t          status;
    logic             skip;
    logic             is_upper, is_digit;
    logic [3:0]       digit;
    method_kind_t     classified;
    logic             accept;

    assign accept   = s_valid && s_ready;
    assign s_ready  = !out_valid_reg || m_ready;
    assign c        = s_data_byte;
    assign cur      = (phase_reg == PH_START) ? '0 : offset_reg;
    assign is_upper = (c >= CH_A_UP) && (c <= CH_Z_UP);
    assign is_digit = (c >= CH_0) && (c <= CH_9);
    assign digit    = c[3:0];

    // method match on the shifted character window
    always_comb begin
        classified = MK_UNKNOWN;
        if (mlen_reg == 3'd3 && mchars_reg[23:0] == WORD_GET) begin
            classified = MK_GET;
        end else if (mlen_reg == 3'd4 && mchars_reg == WORD_HEAD) begin
            classified = MK_HEAD;
        end else if (mlen_reg == 3'd4 && mchars_reg == WORD_POST) begin
            classified = MK_POST;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        mchars_next    = mchars_reg;
        mlen_next      = mlen_reg;
        mcode_next     = mcode_reg;
        uri_start_next = uri_start_reg;
        uri_end_next   = uri_end_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        offset_next    = offset_reg;
        status         = ST_MORE;
        line_end       = '0;
        skip           = 1'b0;

        if (phase_reg == PH_START && (c == CH_CR || c == CH_LF)) begin
            // blank bytes ahead of the method are dropped
            skip = 1'b1;
        end else if (cur >= OFF_W'(LINE_MAX)) begin
            status = ST_BAD_REQ;
        end else begin
            unique case (phase_reg)
                PH_START: begin
                    if (!is_upper) begin
                        status = ST_BAD_METHOD;
                    end else begin
                        mchars_next = {24'd0, c};
                        mlen_next   = 3'd1;
                        phase_next  = PH_METHOD;
                    end
                end
                PH_METHOD: begin
                    if (c == CH_SP) begin
                        mcode_next = classified;
                        phase_next = PH_SP_URI;
                    end else if (!is_upper) begin
                        status = ST_BAD_METHOD;
                    end else begin
                        mchars_next = {mchars_reg[23:0], c};
                        if (mlen_reg != 3'd7) begin
                            mlen_next = mlen_reg + 3'd1;
                        end
                    end
                end
                PH_SP_URI: begin
                    if (c == CH_SLASH) begin
                        uri_start_next = cur;
                        phase_next     = PH_URI;
                    end else if (c != CH_SP) begin
                        status = ST_BAD_REQ;
                    end
                end
                PH_URI: begin
                    if (c == CH_SP) begin
                        uri_end_next = cur;
                        phase_next   = PH_SP_HTTP;
                    end
                end
                PH_SP_HTTP: begin
                    if (c == CH_H) begin
                        phase_next = PH_H;
                    end else if (c != CH_SP) begin
                        status = ST_BAD_REQ;
                    end
                end
                PH_H: begin
                    if (c != CH_T) status = ST_BAD_REQ;
                    else           phase_next = PH_HT;
                end
                PH_HT: begin
                    if (c != CH_T) status = ST_BAD_REQ;
                    else           phase_next = PH_HTT;
                end
                PH_HTT: begin
                    if (c != CH_P) status = ST_BAD_REQ;
                    else           phase_next = PH_HTTP;
                end
                PH_HTTP: begin
                    if (c != CH_SLASH) status = ST_BAD_REQ;
                    else               phase_next = PH_MAJ_FIRST;
                end
                PH_MAJ_FIRST: begin
                    // no leading zero on the major version
                    if (c < CH_1 || c > CH_9) begin
                        status = ST_BAD_REQ;
                    end else begin
                        major_next = VER_W'(digit);
                        phase_next = PH_MAJ;
                    end
                end
                PH_MAJ: begin
                    if (c == CH_DOT) begin
                        phase_next = PH_MIN_FIRST;
                    end else if (!is_digit) begin
                        status = ST_BAD_REQ;
                    end else begin
                        major_next = add_digit(major_reg, digit);
                    end
                end
                PH_MIN_FIRST: begin
                    if (!is_digit) begin
                        status = ST_BAD_REQ;
                    end else begin
                        minor_next = VER_W'(digit);
                        phase_next = PH_MIN;
                    end
                end
                PH_MIN, PH_SP_END: begin
                    if (c == CH_CR) begin
                        phase_next = PH_CR;
                    end else if (c == CH_LF) begin
                        status   = ST_DONE;
                        line_end = cur;
                    end else if (c == CH_SP) begin
                        phase_next = PH_SP_END;
                    end else if (phase_reg == PH_MIN && is_digit) begin
                        minor_next = add_digit(minor_reg, digit);
                    end else begin
                        status = ST_BAD_REQ;
                    end
                end
                PH_CR: begin
                    if (c != CH_LF) begin
                        status = ST_BAD_REQ;
                    end else begin
                        // line end points at the cr
                        status   = ST_DONE;
                        line_end = cur - OFF_W'(1);
                    end
                end
                default: status = ST_BAD_REQ;
            endcase
        end

        if (status != ST_MORE) begin
            // finished or failed line: back to the start phase
            phase_next     = PH_START;
            offset_next    = '0;
            mchars_next    = '0;
            mlen_next      = '0;
            mcode_next     = MK_UNKNOWN;
            uri_start_next = '0;
            uri_end_next   = '0;
            major_next     = '0;
            minor_next     = '0;
        end else if (!skip) begin
            offset_next = cur + OFF_W'(1);
        end
    end

    // parse state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            offset_reg    <= '0;
            mchars_reg    <= '0;
            mlen_reg      <= '0;
            mcode_reg     <= MK_UNKNOWN;
            uri_start_reg <= '0;
            uri_end_reg   <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg     <= phase_next;
                offset_reg    <= offset_next;
                mchars_reg    <= mchars_next;
                mlen_reg      <= mlen_next;
                mcode_reg     <= mcode_next;
                uri_start_reg <= uri_start_next;
                uri_end_reg   <= uri_end_next;
                major_reg     <= major_next;
                minor_reg     <= minor_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, fields other than status are zero unless the line is done
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg <= status;
            if (status == ST_DONE) begin
                out_kind_reg <= mcode_reg;
                out_ubeg_reg <= uri_start_reg[OUT_OFF_W-1:0];
                out_uend_reg <= uri_end_reg[OUT_OFF_W-1:0];
                out_lend_reg <= line_end[OUT_OFF_W-1:0];
                out_maj_reg  <= major_reg;
                out_min_reg  <= minor_reg;
            end else begin
                out_kind_reg <= MK_UNKNOWN;
                out_ubeg_reg <= '0;
                out_uend_reg <= '0;
                out_lend_reg <= '0;
                out_maj_reg  <= '0;
                out_min_reg  <= '0;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_method_kind   = out_kind_reg;
    assign m_uri_begin     = out_ubeg_reg;
    assign m_uri_finish    = out_uend_reg;
    assign m_line_finish   = out_lend_reg;
    assign m_version_major = out_maj_reg;
    assign m_version_minor = out_min_reg;

endmodule

// ----- sim/http_request_line_parser_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_parser_test
// self-checking bench for the request line parser: a short table of
// hand-picked bytes, then random request lines (clean, damaged and noise),
// each word checked against a byte-by-byte parser model or a hand-typed row, in the bench
// ----------------------------------------------------------------------------
module http_request_line_parser_test
    import hrlp_pkg::*;
();

    localparam int RANDOM_BYTES = 1100;   // stimulus stops once this many random bytes went in
    localparam int HOLD_CYCLES  = 300;    // one long stall on the result side
    localparam int HOLD_AFTER   = 200;    // words seen before that stall starts
    localparam int SHOW_MAX     = 10;     // mismatches printed in full

    // parse phases of the model, one per position in the request line
    typedef enum int {
        PH_IDLE, PH_METHOD, PH_GAP_URI, PH_URI, PH_GAP_PROTO, PH_H, PH_HT, PH_HTT,
        PH_HTTP, PH_MAJ_LEAD, PH_MAJ, PH_MIN_LEAD, PH_MIN, PH_TRAIL, PH_CR
    } parse_phase_t;

    // one result word as the block reports it
    typedef struct {
        status_t              status;
        method_kind_t         kind;
        logic [OUT_OFF_W-1:0] uri_begin;
        logic [OUT_OFF_W-1:0] uri_finish;
        logic [OUT_OFF_W-1:0] line_finish;
        logic [VER_W-1:0]     major;
        logic [VER_W-1:0]     minor;
    } line_word_t;

    // directed table row: a byte, and a status typed in by hand when fixed is set
    typedef struct {
        logic [7:0] data;
        bit         fixed;
        status_t    status;
    } stim_row_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_data_byte = 8'h00;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [1:0]           m_status;
    logic [1:0]           m_method_kind;
    logic [OUT_OFF_W-1:0] m_uri_begin;
    logic [OUT_OFF_W-1:0] m_uri_finish;
    logic [OUT_OFF_W-1:0] m_line_finish;
    logic [VER_W-1:0]     m_version_major;
    logic [VER_W-1:0]     m_version_minor;

    // parser model state
    parse_phase_t     ph;
    int               line_pos;
    logic [31:0]      meth_word;
    int               meth_len;
    method_kind_t     meth_kind;
    int               uri_lo;
    int               uri_hi;
    logic [VER_W-1:0] ver_major;
    logic [VER_W-1:0] ver_minor;

    line_word_t expected_words[$];   // words still owed by the block, oldest first
    stim_row_t  directed_rows[$];
    logic [7:0] line_bytes[$];       // request line being assembled for sending
    int         fail_count  = 0;
    int         words_seen  = 0;
    int         random_sent = 0;
    bit         sender_calm = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    http_request_line_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_method_kind   (m_method_kind),
        .m_uri_begin     (m_uri_begin),
        .m_uri_finish    (m_uri_finish),
        .m_line_finish   (m_line_finish),
        .m_version_major (m_version_major),
        .m_version_minor (m_version_minor)
    );

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    function automatic void clear_parse();
        ph        = PH_IDLE;
        line_pos  = 0;
        meth_word = '0;
        meth_len  = 0;
        meth_kind = MK_UNKNOWN;
        uri_lo    = 0;
        uri_hi    = 0;
        ver_major = '0;
        ver_minor = '0;
    endfunction

    function automatic bit is_upper(input logic [7:0] c);
        return c >= CH_A_UP && c <= CH_Z_UP;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    // decimal shift-in of one digit, clamped at the largest reportable version
    function automatic logic [VER_W-1:0] bump_version(input logic [VER_W-1:0] acc,
                                                      input logic [7:0] c);
        int v;
        v = int'(acc) * 10 + int'(c - CH_0);
        if (v > int'(VER_SAT)) begin
            v = int'(VER_SAT);
        end
        return VER_W'(v);
    endfunction

    // only the exact length counts: a longer name ending in a known one is unknown
    function automatic method_kind_t method_from_word();
        if (meth_len == 3 && meth_word[23:0] == WORD_GET) begin
            return MK_GET;
        end
        if (meth_len == 4 && meth_word == WORD_HEAD) begin
            return MK_HEAD;
        end
        if (meth_len == 4 && meth_word == WORD_POST) begin
            return MK_POST;
        end
        return MK_UNKNOWN;
    endfunction

    // build the word for a verdict; fields other than status stay zero unless done,
    // and any verdict but need-more starts a fresh line
    function automatic line_word_t settle_word(input status_t verdict, input int line_end);
        line_word_t w;
        w.status      = verdict;
        w.kind        = MK_UNKNOWN;
        w.uri_begin   = '0;
        w.uri_finish  = '0;
        w.line_finish = '0;
        w.major       = '0;
        w.minor       = '0;
        if (verdict == ST_DONE) begin
            w.kind        = meth_kind;
            w.uri_begin   = OUT_OFF_W'(uri_lo);
            w.uri_finish  = OUT_OFF_W'(uri_hi);
            w.line_finish = OUT_OFF_W'(line_end);
            w.major       = ver_major;
            w.minor       = ver_minor;
        end
        if (verdict != ST_MORE) begin
            clear_parse();
        end
        return w;
    endfunction

    // advance the model by one byte and return the word it should produce
    function automatic line_word_t parse_byte(input logic [7:0] c);
        int      cur;
        int      line_end;
        status_t verdict;
        cur      = (ph == PH_IDLE) ? 0 : line_pos;
        line_end = 0;
        verdict  = ST_MORE;
        // blank bytes ahead of the method do not move the offset
        if (ph == PH_IDLE && (c == CH_CR || c == CH_LF)) begin
            return settle_word(ST_MORE, 0);
        end
        if (cur >= LINE_MAX) begin
            return settle_word(ST_BAD_REQ, 0);
        end
        case (ph)
            PH_IDLE: begin
                if (is_upper(c)) begin
                    meth_word = {24'h000000, c};
                    meth_len  = 1;
                    ph        = PH_METHOD;
                end else begin
                    verdict = ST_BAD_METHOD;
                end
            end
            PH_METHOD: begin
                if (c == CH_SP) begin
                    meth_kind = method_from_word();
                    ph        = PH_GAP_URI;
                end else if (!is_upper(c)) begin
                    verdict = ST_BAD_METHOD;
                end else begin
                    meth_word = {meth_word[23:0], c};
                    if (meth_len < 7) begin
                        meth_len++;
                    end
                end
            end
            PH_GAP_URI: begin
                if (c == CH_SLASH) begin
                    uri_lo = cur;
                    ph     = PH_URI;
                end else if (c != CH_SP) begin
                    verdict = ST_BAD_REQ;
                end
            end
            PH_URI: begin
                if (c == CH_SP) begin
                    uri_hi = cur;
                    ph     = PH_GAP_PROTO;
                end
            end
            PH_GAP_PROTO: begin
                if (c == CH_H) begin
                    ph = PH_H;
                end else if (c != CH_SP) begin
                    verdict = ST_BAD_REQ;
                end
            end
            PH_H: begin
                if (c == CH_T) ph = PH_HT;
                else verdict = ST_BAD_REQ;
            end
            PH_HT: begin
                if (c == CH_T) ph = PH_HTT;
                else verdict = ST_BAD_REQ;
            end
            PH_HTT: begin
                if (c == CH_P) ph = PH_HTTP;
                else verdict = ST_BAD_REQ;
            end
            PH_HTTP: begin
                if (c == CH_SLASH) ph = PH_MAJ_LEAD;
                else verdict = ST_BAD_REQ;
            end
            PH_MAJ_LEAD: begin
                if (c >= CH_1 && c <= CH_9) begin
                    ver_major = VER_W'(c - CH_0);
                    ph        = PH_MAJ;
                end else begin
                    verdict = ST_BAD_REQ;
                end
            end
            PH_MAJ: begin
                if (c == CH_DOT) begin
                    ph = PH_MIN_LEAD;
                end else if (is_digit(c)) begin
                    ver_major = bump_version(ver_major, c);
                end else begin
                    verdict = ST_BAD_REQ;
                end
            end
            PH_MIN_LEAD: begin
                if (is_digit(c)) begin
                    ver_minor = VER_W'(c - CH_0);
                    ph        = PH_MIN;
                end else begin
                    verdict = ST_BAD_REQ;
                end
            end
            PH_MIN, PH_TRAIL: begin
                if (c == CH_CR) begin
                    ph = PH_CR;
                end else if (c == CH_LF) begin
                    verdict  = ST_DONE;
                    line_end = cur;
                end else if (c == CH_SP) begin
                    ph = PH_TRAIL;
                end else if (ph == PH_MIN && is_digit(c)) begin
                    ver_minor = bump_version(ver_minor, c);
                end else begin
                    verdict = ST_BAD_REQ;
                end
            end
            PH_CR: begin
                // line end points at the CR, one byte back
                if (c == CH_LF) begin
                    verdict  = ST_DONE;
                    line_end = cur - 1;
                end else begin
                    verdict = ST_BAD_REQ;
                end
            end
            default: verdict = ST_BAD_REQ;
        endcase
        if (verdict == ST_MORE) begin
            line_pos = cur + 1;
        end
        return settle_word(verdict, line_end);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // idle length: mostly none, some short, a few long; none at all in calm stretches
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] upper_char();
        return 8'(CH_A_UP + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'(CH_0 + $urandom_range(0, 9));
    endfunction

    // anything but a space may sit inside the uri, control and high bytes included
    function automatic logic [7:0] uri_char();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_SP);
        return b;
    endfunction

    function automatic void add_row(input logic [7:0] data, input bit fixed,
                                    input status_t status);
        stim_row_t row;
        row.data   = data;
        row.fixed  = fixed;
        row.status = status;
        directed_rows.push_back(row);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_bytes.push_back(s[i]);
        end
    endfunction

    // offer one byte, wait for it to be taken, then log the word it owes
    task automatic send_byte(input logic [7:0] b, input bit fixed, input status_t status);
        line_word_t w;
        int         gap;
        gap = pick_gap(sender_calm);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do begin
            @(posedge aclk);
        end while (s_ready !== 1'b1);
        w = parse_byte(b);
        if (fixed) begin
            // hand-typed rows: every field but status is zero
            w.status      = status;
            w.kind        = MK_UNKNOWN;
            w.uri_begin   = '0;
            w.uri_finish  = '0;
            w.line_finish = '0;
            w.major       = '0;
            w.minor       = '0;
        end
        expected_words.push_back(w);
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) begin
            send_byte(line_bytes[i], 1'b0, ST_MORE);
        end
        line_bytes.delete();
    endtask

    // stop offering and let every owed word come back, giving up once the budget runs out
    task automatic wait_for_results(input int budget);
        int n;
        n = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0 && n < budget) begin
            @(posedge aclk);
            n++;
        end
    endtask

    // well-formed request line with random content; a leading-zero major is
    // the only deliberate flaw here
    task automatic build_request_line(input bit zero_major);
        int pick;
        line_bytes.delete();
        repeat ($urandom_range(0, 2)) begin
            line_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
        pick = $urandom_range(0, 6);
        case (pick)
            0: put_text("GET");
            1: put_text("HEAD");
            2: put_text("POST");
            3: begin
                // near misses of the known names
                case ($urandom_range(0, 2))
                    0: put_text("GE");
                    1: put_text("HEA");
                    default: put_text("POS");
                endcase
                line_bytes.push_back(upper_char());
            end
            default: begin
                // free-form name, long enough to hit the length clamp, at times
                // carrying a known name at its tail
                repeat ($urandom_range(1, 9)) begin
                    line_bytes.push_back(upper_char());
                end
                if (pick == 6) begin
                    put_text("HEAD");
                end
            end
        endcase
        repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_SP);
        line_bytes.push_back(CH_SLASH);
        repeat ($urandom_range(0, 6)) line_bytes.push_back(uri_char());
        repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_SP);
        put_text("HTTP/");
        line_bytes.push_back(zero_major ? CH_0 : 8'(CH_1 + $urandom_range(0, 8)));
        // up to five digits so the major clamps now and then
        repeat ($urandom_range(0, 4)) line_bytes.push_back(digit_char());
        line_bytes.push_back(CH_DOT);
        repeat ($urandom_range(1, 5)) line_bytes.push_back(digit_char());
        repeat ($urandom_range(0, 2)) line_bytes.push_back(CH_SP);
        if ($urandom_range(0, 1)) begin
            line_bytes.push_back(CH_CR);
        end
        line_bytes.push_back(CH_LF);
    endtask

    // ------------------------------------------------------------------
    // result side: ready pattern and word checker
    // ------------------------------------------------------------------

    // random stalls, calm stretches with none, and one long hold-off once
    // enough words went by so the output register fills and s_ready drops
    initial begin : sink_ready
        int hold;
        bit calm;
        bit held_long;
        hold      = 0;
        calm      = 1'b0;
        held_long = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!held_long && words_seen >= HOLD_AFTER) begin
                held_long = 1'b1;
                hold      = HOLD_CYCLES;
            end
            if ($urandom_range(0, 63) == 0) begin
                calm = ($urandom_range(0, 2) == 0);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                hold = pick_gap(calm);
            end
        end
    end

    // every word taken is matched against the oldest one owed
    always @(posedge aclk) begin : check_words
        line_word_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOW_MAX) begin
                    $display("%0t: word with none owed, status %0d", $realtime, m_status);
                end
            end else begin
                want = expected_words.pop_front();
                if (m_status !== want.status || m_method_kind !== want.kind ||
                    m_uri_begin !== want.uri_begin || m_uri_finish !== want.uri_finish ||
                    m_line_finish !== want.line_finish ||
                    m_version_major !== want.major || m_version_minor !== want.minor) begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX) begin
                        $display("%0t: word %0d mismatch", $realtime, words_seen);
                        $display("  want st %0d mk %0d uri %0d..%0d end %0d ver %0d.%0d",
                                 want.status, want.kind, want.uri_begin, want.uri_finish,
                                 want.line_finish, want.major, want.minor);
                        $display("  got  st %0d mk %0d uri %0d..%0d end %0d ver %0d.%0d",
                                 m_status, m_method_kind, m_uri_begin, m_uri_finish,
                                 m_line_finish, m_version_major, m_version_minor);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        string hello;
        int    line_count;
        int    roll;
        clear_parse();
        line_count = 0;
        hello      = "GET / HTTP/1.1";

        // reset held low from the start, released on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table: blank bytes before a method, extreme and lower-case
        // first bytes, one clean CRLF line, and a bad uri start
        add_row(CH_CR, 1'b1, ST_MORE);
        add_row(CH_LF, 1'b1, ST_MORE);
        add_row(8'h00, 1'b1, ST_BAD_METHOD);
        add_row(8'hff, 1'b1, ST_BAD_METHOD);
        add_row("a",   1'b1, ST_BAD_METHOD);
        for (int i = 0; i < hello.len(); i++) begin
            add_row(hello[i], 1'b0, ST_MORE);
        end
        add_row(CH_CR, 1'b0, ST_MORE);
        add_row(CH_LF, 1'b0, ST_MORE);
        add_row("X",   1'b0, ST_MORE);
        add_row(CH_SP, 1'b0, ST_MORE);
        add_row("Y",   1'b1, ST_BAD_REQ);
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].data, directed_rows[i].fixed, directed_rows[i].status);
        end

        // random lines: mostly well formed, some damaged at one spot, some noise
        while (random_sent < RANDOM_BYTES) begin
            line_count++;
            if (line_count % 8 == 0) begin
                sender_calm = ($urandom_range(0, 3) == 0);
            end
            if (line_count == 17) begin
                // sender pause until the block has answered everything
                wait_for_results(1_000_000);
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                build_request_line(roll < 5);
            end else if (roll < 88) begin
                build_request_line(1'b0);
                line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            end else begin
                line_bytes.delete();
                repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            random_sent += line_bytes.size();
            send_line();
        end

        // drain, then a few quiet cycles to catch any stray word
        wait_for_results(5000);
        repeat (8) @(posedge aclk);
        if (expected_words.size() != 0) begin
            fail_count++;
            $display("%0d words never arrived", expected_words.size());
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hard stop in case the handshake hangs
    initial begin : watchdog
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/hrlp_pkg.sv
hw/rtl/http_request_line_parser.sv
sim/http_request_line_parser_test.sv
